// ===== rtl/lea_pkg.sv =====
// shared constants, codes and types of the lifo extent allocator
`default_nettype none

package lea_pkg;

   // sizes
   localparam int STACK_DEPTH  = 256;
   localparam int ADDR_BITS    = 40;
   localparam int IDX_BITS     = $clog2(STACK_DEPTH);
   localparam int CNT_BITS     = $clog2(STACK_DEPTH + 1);
   localparam int WANT_BITS    = ADDR_BITS + 1;
   localparam int FRAG_BITS    = 5;
   localparam int CSR_IDX_BITS = 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_NO_MEMORY = 2'd1;
   localparam logic [1:0] ST_FREED     = 2'd2;
   localparam logic [1:0] ST_DROPPED   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_BASE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_LENGTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAGMENT_LOG2 = 2'd2;

   // classified item travelling from front to back
   typedef struct packed {
      logic                 operation;
      logic [WANT_BITS-1:0] want;
      logic [ADDR_BITS-1:0] amount;
      logic [ADDR_BITS-1:0] extent_addr;
   } queue_item_type;

   // one stack entry
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [ADDR_BITS-1:0] length;
   } extent_type;

   // region settings seen by the back end
   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] length;
      logic                 reinit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/lea_front.sv =====
// front end: accepts items and rounds allocate requests up to the fragment size
`default_nettype none

module lea_front import lea_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [FRAG_BITS-1:0] fragment_log2,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_operation,
   input  wire logic [ADDR_BITS-1:0] req_amount,
   input  wire logic [ADDR_BITS-1:0] req_extent_addr,
   output logic                      q_push,
   input  wire logic                 q_ready,
   output queue_item_type            q_item
);

   logic           stage_valid_ff;
   logic           stage_valid_in;
   queue_item_type stage_ff;
   queue_item_type stage_in;
   logic [WANT_BITS-1:0] frag_mask;
   logic [ADDR_BITS-1:0] rem_bits;
   logic                 accepted;

   // round-up: fill the low bits and add one when any of them was set
   always_comb begin
      frag_mask = ~({WANT_BITS{1'b1}} << fragment_log2);
      rem_bits  = req_amount & frag_mask[ADDR_BITS-1:0];
      stage_in.operation   = req_operation;
      stage_in.amount      = req_amount;
      stage_in.extent_addr = req_extent_addr;
      if (rem_bits == '0) begin
         stage_in.want = {1'b0, req_amount};
      end else begin
         stage_in.want = {1'b0, req_amount | frag_mask[ADDR_BITS-1:0]} + WANT_BITS'(1);
      end
   end

   // handshake with the queue
   assign req_ready = !stage_valid_ff || q_ready;
   assign accepted  = req_valid && req_ready;
   assign q_push    = stage_valid_ff;
   assign q_item    = stage_ff;

   always_comb begin
      if (accepted) begin
         stage_valid_in = 1'b1;
      end else if (q_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accepted) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lea_queue.sv =====
// short queue of classified items between front and back end
`default_nettype none

module lea_queue import lea_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          push_ready,
   input  wire queue_item_type push_item,
   output logic          pop_valid,
   input  wire logic     pop,
   output queue_item_type pop_item
);

   queue_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lea_back.sv =====
// back end: runs items against the extent stack and holds the result register
`default_nettype none

module lea_back import lea_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  q_valid,
   input  wire queue_item_type        q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ADDR_BITS-1:0]       rsp_grant_addr,
   output logic [ADDR_BITS-1:0]       rsp_grant_length,
   output logic [1:0]                 rsp_status,
   output logic [ADDR_BITS-1:0]       rsp_used_bytes
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type            state_ff;
   queue_item_type       work_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [CNT_BITS-1:0]  cnt_in;
   logic [ADDR_BITS-1:0] used_ff;
   logic [ADDR_BITS-1:0] used_in;
   logic                 e0_valid_ff;
   logic                 rd_zero_ff;
   extent_type           rd_data_ff;
   extent_type           stack_mem [STACK_DEPTH];

   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_addr_ff;
   logic [ADDR_BITS-1:0] rsp_len_ff;
   logic [1:0]           rsp_status_ff;

   logic                 out_free;
   logic                 fire;
   logic [CNT_BITS-1:0]  top_cnt;
   logic [IDX_BITS-1:0]  rd_idx;
   extent_type           top_ext;
   logic [ADDR_BITS+1:0] diff;
   logic                 longer;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx;
   extent_type           wr_ext;
   logic [ADDR_BITS-1:0] g_addr;
   logic [ADDR_BITS-1:0] g_len;
   logic [1:0]           status;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = (state_ff == S_EXEC) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign top_cnt  = cnt_ff - CNT_BITS'(1);
   assign rd_idx   = top_cnt[IDX_BITS-1:0];

   // bottom entry reads as the region until first written
   assign top_ext = (rd_zero_ff && !e0_valid_ff)
                    ? extent_type'{addr: cfg.base, length: cfg.length}
                    : rd_data_ff;

   // one subtraction gives both the compare and the tail length
   assign diff   = {2'b00, top_ext.length} - {1'b0, work_ff.want};
   assign longer = !diff[ADDR_BITS+1] && (diff != '0);

   // execute step
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = cnt_ff[IDX_BITS-1:0];
      wr_ext  = '{addr: work_ff.extent_addr, length: work_ff.amount};
      cnt_in  = cnt_ff;
      used_in = used_ff;
      g_addr  = '0;
      g_len   = '0;
      status  = ST_NO_MEMORY;
      if (fire) begin
         if (work_ff.operation == OP_ALLOC) begin
            if (cnt_ff != '0) begin
               status = ST_ALLOCATED;
               g_addr = top_ext.addr;
               if (longer) begin
                  // front is granted, tail goes back where the extent was
                  g_len  = work_ff.want[ADDR_BITS-1:0];
                  wr_en  = 1'b1;
                  wr_idx = rd_idx;
                  wr_ext = '{addr: top_ext.addr + work_ff.want[ADDR_BITS-1:0],
                             length: diff[ADDR_BITS-1:0]};
               end else begin
                  g_len  = top_ext.length;
                  cnt_in = top_cnt;
               end
               used_in = used_ff + g_len;
            end
         end else begin
            used_in = used_ff - work_ff.amount;
            if (cnt_ff < CNT_BITS'(STACK_DEPTH)) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_BITS'(1);
               status = ST_FREED;
            end else begin
               status = ST_DROPPED;
            end
         end
      end
      if (cfg.reinit) begin
         cnt_in  = CNT_BITS'(1);
         used_in = '0;
      end
   end

   // sequencer, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= CNT_BITS'(1);
         used_ff      <= '0;
         e0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         used_ff <= used_in;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cfg.reinit) begin
            e0_valid_ff <= 1'b0;
         end else if (wr_en && (wr_idx == '0)) begin
            e0_valid_ff <= 1'b1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         work_ff <= q_item;
      end
      if (fire) begin
         rsp_addr_ff   <= g_addr;
         rsp_len_ff    <= g_len;
         rsp_status_ff <= status;
      end
   end

   // extent stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_ext;
      end
      if (q_pop) begin
         rd_data_ff <= stack_mem[rd_idx];
         rd_zero_ff <= (rd_idx == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grant_addr   = rsp_addr_ff;
   assign rsp_grant_length = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_used_bytes   = used_ff;

   // stack level never passes its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // a finished item always shows up in the result register
   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("finished item not presented");

   // a grant is never longer than the rounded request
   a_grant_len: assert property (@(posedge clock) disable iff (reset)
      (fire && work_ff.operation == OP_ALLOC && cnt_ff != '0)
         |-> ({1'b0, g_len} <= work_ff.want))
      else $error("grant longer than request");

   // an accepted free on a non-full stack raises the level by one
   a_free_push: assert property (@(posedge clock) disable iff (reset)
      (fire && work_ff.operation == OP_FREE && cnt_ff < CNT_BITS'(STACK_DEPTH)
         && !cfg.reinit) |=> (cnt_ff == $past(cnt_ff) + CNT_BITS'(1)))
      else $error("free did not push");

endmodule

`default_nettype wire

// ===== rtl/lifo_extent_allocator.sv =====
// top level of the lifo extent allocator: settings registers and the three parts
// Usage:
//   req_ channel carries one item: operation (allocate or free), amount and
//   extent_addr. rsp_ channel returns one item per request, in order, with the
//   granted extent, a status code and the running used-bytes count.
//   csr_ port writes region_base, region_length and fragment_log2; writing
//   either region register rebuilds the stack as the single whole region and
//   clears the used-bytes count. Write only while the block is idle.
// Flow:
//   a request passes the front stage register and a queue slot to the
//   back end. Its sequencer reads the stack top from the extent memory as it
//   takes the item, updates it and writes back in its execute state, and
//   takes no new item until that one has moved into the result register.
// Stalls:
//   the result register holds its item until rsp_ready; meanwhile the front
//   stage and a two-entry queue keep taking requests until they fill.
// Reset:
//   synchronous; the stack holds the region (0, 1 MiB), fragments are 256
//   bytes and used bytes are zero. No clearing pass is needed.
`default_nettype none

module lifo_extent_allocator import lea_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_operation,
   input  wire logic [ADDR_BITS-1:0]    req_amount,
   input  wire logic [ADDR_BITS-1:0]    req_extent_addr,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [ADDR_BITS-1:0]         rsp_grant_addr,
   output logic [ADDR_BITS-1:0]         rsp_grant_length,
   output logic [1:0]                   rsp_status,
   output logic [ADDR_BITS-1:0]         rsp_used_bytes,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [ADDR_BITS-1:0]    csr_wdata
);

   logic [ADDR_BITS-1:0] base_ff;
   logic [ADDR_BITS-1:0] length_ff;
   logic [FRAG_BITS-1:0] frag_ff;
   cfg_type              cfg;
   logic                 q_push;
   logic                 q_ready;
   queue_item_type       q_in_item;
   logic                 q_valid;
   logic                 q_pop;
   queue_item_type       q_out_item;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         length_ff <= ADDR_BITS'(1048576);
         frag_ff   <= FRAG_BITS'(8);
      end else if (csr_we) begin
         case (csr_index)
            CSR_REGION_BASE:   base_ff   <= csr_wdata;
            CSR_REGION_LENGTH: length_ff <= csr_wdata;
            CSR_FRAGMENT_LOG2: frag_ff   <= csr_wdata[FRAG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // region view for the back end, with the rebuild pulse
   assign cfg.base   = base_ff;
   assign cfg.length = length_ff;
   assign cfg.reinit = csr_we && ((csr_index == CSR_REGION_BASE)
                                  || (csr_index == CSR_REGION_LENGTH));

   lea_front u_front (
      .clock           (clock),
      .reset           (reset),
      .fragment_log2   (frag_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_amount      (req_amount),
      .req_extent_addr (req_extent_addr),
      .q_push          (q_push),
      .q_ready         (q_ready),
      .q_item          (q_in_item)
   );

   lea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_ready),
      .push_item  (q_in_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_out_item)
   );

   lea_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_item           (q_out_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_addr   (rsp_grant_addr),
      .rsp_grant_length (rsp_grant_length),
      .rsp_status       (rsp_status),
      .rsp_used_bytes   (rsp_used_bytes)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the lifo extent allocator: directed rows, random phases, csr sweeps
`timescale 1ns / 1ps

module tb import lea_pkg::*; ();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 250;
   localparam int FILL_BURST   = 270;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;
   localparam logic [ADDR_BITS-1:0] MAX_VAL = '1;

   // one result item as the block reports it
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [ADDR_BITS-1:0] length;
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] used;
   } grant_type;

   // one directed row; typed rows carry their result written out by hand
   typedef struct packed {
      logic                 op;
      logic [ADDR_BITS-1:0] amount;
      logic [ADDR_BITS-1:0] addr;
      logic                 typed;
      grant_type            grant;
   } directed_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_operation;
   logic [ADDR_BITS-1:0]    req_amount;
   logic [ADDR_BITS-1:0]    req_extent_addr;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [ADDR_BITS-1:0]    rsp_grant_addr;
   logic [ADDR_BITS-1:0]    rsp_grant_length;
   logic [1:0]              rsp_status;
   logic [ADDR_BITS-1:0]    rsp_used_bytes;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [ADDR_BITS-1:0]    csr_wdata;

   // predictor state: free-extent stack, used-bytes count and settings
   logic [ADDR_BITS-1:0] free_addr [STACK_DEPTH];
   logic [ADDR_BITS-1:0] free_len  [STACK_DEPTH];
   int                   free_count;
   logic [ADDR_BITS-1:0] used_count;
   logic [ADDR_BITS-1:0] cfg_base;
   logic [ADDR_BITS-1:0] cfg_length;
   logic [FRAG_BITS-1:0] cfg_frag_log2;

   grant_type  pending_grants[$];
   extent_type held_extents[$];
   grant_type  oldest_grant;

   int  send_idle_pct = 37;
   int  recv_idle_pct = 60;
   bit  hold_armed    = 1'b0;
   int  hold_count    = 0;
   int  cycle_count   = 0;
   int  fail_count    = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  status_seen [4] = '{0, 0, 0, 0};

   // directed rows, walked in order from the reset settings
   directed_row_type directed_rows [21] = '{
      '{OP_ALLOC, 40'd0, 40'd0, 1'b1, '{40'd0, 40'd0, ST_ALLOCATED, 40'd0}},
      '{OP_ALLOC, 40'd1, MAX_VAL, 1'b1, '{40'd0, 40'd256, ST_ALLOCATED, 40'd256}},
      '{OP_ALLOC, 40'd255, 40'd0, 1'b0, '0},
      '{OP_ALLOC, 40'd256, 40'd0, 1'b0, '0},
      '{OP_ALLOC, MAX_VAL, 40'd0, 1'b0, '0},
      '{OP_ALLOC, 40'd0, 40'd0, 1'b1, '{40'd0, 40'd0, ST_NO_MEMORY, 40'h10_0000}},
      '{OP_ALLOC, MAX_VAL, MAX_VAL, 1'b1, '{40'd0, 40'd0, ST_NO_MEMORY, 40'h10_0000}},
      '{OP_FREE, 40'd0, 40'd0, 1'b1, '{40'd0, 40'd0, ST_FREED, 40'h10_0000}},
      '{OP_ALLOC, 40'd5, 40'd0, 1'b0, '0},
      '{OP_FREE, MAX_VAL, MAX_VAL, 1'b1, '{40'd0, 40'd0, ST_FREED, 40'h10_0001}},
      '{OP_ALLOC, 40'd1, 40'd0, 1'b0, '0},
      '{OP_FREE, 40'd1024, 40'hFF_FFFF_FF00, 1'b0, '0},
      '{OP_ALLOC, 40'd256, 40'd0, 1'b0, '0},
      '{OP_ALLOC, 40'd768, 40'd0, 1'b0, '0},
      '{OP_FREE, 40'h1000, 40'h12_3456_7800, 1'b0, '0},
      '{OP_ALLOC, 40'hFF_FFFF_FF01, 40'd0, 1'b0, '0},
      '{OP_FREE, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 1'b0, '0},
      '{OP_FREE, 40'h55_5555_5555, 40'hAA_AAAA_AAAA, 1'b0, '0},
      '{OP_ALLOC, 40'h55_5555_5555, 40'd0, 1'b0, '0},
      '{OP_ALLOC, 40'd0, 40'd0, 1'b0, '0},
      '{OP_ALLOC, 40'hAA_AAAA_AAAA, 40'd0, 1'b0, '0}
   };

   lifo_extent_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_amount       (req_amount),
      .req_extent_addr  (req_extent_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_addr   (rsp_grant_addr),
      .rsp_grant_length (rsp_grant_length),
      .rsp_status       (rsp_status),
      .rsp_used_bytes   (rsp_used_bytes),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // stack back to the single whole-region extent
   function automatic void reload_region();
      free_addr[0] = cfg_base;
      free_len[0]  = cfg_length;
      free_count   = 1;
      used_count   = '0;
   endfunction

   function automatic bit push_free(logic [ADDR_BITS-1:0] addr, logic [ADDR_BITS-1:0] len);
      if (free_count >= STACK_DEPTH) return 1'b0;
      free_addr[free_count] = addr;
      free_len[free_count]  = len;
      free_count++;
      return 1'b1;
   endfunction

   // request rounded up to the fragment size, held wider than an address
   function automatic logic [63:0] round_to_fragment(logic [ADDR_BITS-1:0] amount);
      logic [63:0] wide;
      logic [63:0] frag;
      logic [63:0] rem;
      logic [63:0] rounded;
      wide = {{(64-ADDR_BITS){1'b0}}, amount};
      frag = 64'd1 << cfg_frag_log2;
      rem  = wide & (frag - 64'd1);
      if (rem == 64'd0) return wide;
      rounded = wide - rem + frag;
      if (rounded < wide) return '1;
      return rounded;
   endfunction

   // result of one item, updating the stack and the used-bytes count
   function automatic grant_type predict_grant(logic op, logic [ADDR_BITS-1:0] amount,
                                               logic [ADDR_BITS-1:0] addr);
      grant_type            g;
      logic [63:0]          want;
      logic [ADDR_BITS-1:0] top_addr;
      logic [ADDR_BITS-1:0] top_len;
      g = '0;
      if (op == OP_ALLOC) begin
         if (free_count == 0) begin
            g.status = ST_NO_MEMORY;
         end else begin
            want = round_to_fragment(amount);
            free_count--;
            top_addr = free_addr[free_count];
            top_len  = free_len[free_count];
            // longer extent: front is granted, tail goes back on the stack
            if ({{(64-ADDR_BITS){1'b0}}, top_len} > want) begin
               void'(push_free(top_addr + want[ADDR_BITS-1:0],
                               top_len - want[ADDR_BITS-1:0]));
               top_len = want[ADDR_BITS-1:0];
            end
            g.addr     = top_addr;
            g.length   = top_len;
            g.status   = ST_ALLOCATED;
            used_count = used_count + top_len;
         end
      end else begin
         used_count = used_count - amount;
         g.status   = push_free(addr, amount) ? ST_FREED : ST_DROPPED;
      end
      g.used = used_count;
      return g;
   endfunction

   function automatic logic [ADDR_BITS-1:0] rand40();
      logic [7:0] hi;
      hi = 8'($urandom_range(0, 255));
      return {hi, $urandom()};
   endfunction

   // amounts weighted towards small and fragment-aligned sizes
   function automatic logic [ADDR_BITS-1:0] pick_amount();
      logic [ADDR_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = MAX_VAL;
         2: v = rand40();
         3, 4: v = ADDR_BITS'($urandom_range(1, 4096));
         5, 6: begin
            v = ADDR_BITS'($urandom_range(1, 64));
            v = v << cfg_frag_log2;
         end
         7: v = ADDR_BITS'($urandom_range(0, 1 << 20));
         default: v = rand40() >> $urandom_range(0, 39);
      endcase
      return v;
   endfunction

   // offer one item, wait for acceptance, then record what it should return
   task automatic send_item(input logic op, input logic [ADDR_BITS-1:0] amount,
                            input logic [ADDR_BITS-1:0] addr, input logic typed,
                            input grant_type typed_grant);
      grant_type  g;
      extent_type e;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_amount      <= amount;
      req_extent_addr <= addr;
      do begin
         @(posedge clock);
      end while (!req_ready);
      g = predict_grant(op, amount, addr);
      if (g.status == ST_ALLOCATED && g.length != '0) begin
         e.addr   = g.addr;
         e.length = g.length;
         held_extents.push_back(e);
      end
      pending_grants.push_back(typed ? typed_grant : g);
      items_sent++;
   endtask

   // register write while idle; region writes rebuild the stack
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [ADDR_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_REGION_BASE: begin
            cfg_base = data;
            reload_region();
         end
         CSR_REGION_LENGTH: begin
            cfg_length = data;
            reload_region();
         end
         CSR_FRAGMENT_LOG2: cfg_frag_log2 = data[FRAG_BITS-1:0];
         default: ;
      endcase
      held_extents.delete();
   endtask

   // stop offering and let every pending result come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off while the sender keeps going
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && hold_count < HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
            hold_count++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (pending_grants.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("result %0d with nothing pending: %h %h %0d %h",
                        results_seen, rsp_grant_addr, rsp_grant_length, rsp_status,
                        rsp_used_bytes);
         end else begin
            oldest_grant = pending_grants.pop_front();
            if (rsp_grant_addr !== oldest_grant.addr || rsp_grant_length !== oldest_grant.length
                || rsp_status !== oldest_grant.status || rsp_used_bytes !== oldest_grant.used) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("result %0d mismatch: exp %h %h %0d %h, got %h %h %0d %h",
                           results_seen, oldest_grant.addr, oldest_grant.length,
                           oldest_grant.status, oldest_grant.used, rsp_grant_addr,
                           rsp_grant_length, rsp_status, rsp_used_bytes);
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               pending_grants.size());
      $display("lifo_extent_allocator regression: fail");
      $finish;
   end

   // stimulus
   initial begin
      int                   kind;
      int                   n;
      int                   idx;
      int                   issued;
      logic [ADDR_BITS-1:0] base_v;
      logic [ADDR_BITS-1:0] len_v;
      logic [ADDR_BITS-1:0] frag_v;
      extent_type           e;

      req_valid       = 1'b0;
      req_operation   = OP_ALLOC;
      req_amount      = '0;
      req_extent_addr = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_REGION_BASE;
      csr_wdata       = '0;
      reset           = 1'b1;
      cfg_base        = '0;
      cfg_length      = 40'h10_0000;
      cfg_frag_log2   = 5'd8;
      reload_region();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows on the reset settings
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].amount, directed_rows[i].addr,
                   directed_rows[i].typed, directed_rows[i].grant);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // idling: sender-light then receiver-light, then none
         if (p == 2) begin
            send_idle_pct = 60;
            recv_idle_pct <= 37;
         end
         if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end

         // region and fragment settings for this phase, extremes first
         case (p)
            0: begin
               base_v = '0;
               len_v  = MAX_VAL;
               frag_v = '0;
            end
            1: begin
               base_v = MAX_VAL;
               len_v  = MAX_VAL;
               frag_v = ADDR_BITS'(30);
            end
            2: begin
               base_v = rand40();
               len_v  = '0;
               frag_v = ADDR_BITS'($urandom_range(1, 29));
            end
            3: begin
               base_v = rand40();
               len_v  = ADDR_BITS'($urandom_range(0, 1 << 20));
               frag_v = ADDR_BITS'(12);
            end
            4: begin
               base_v = rand40();
               len_v  = rand40();
               frag_v = '0;
            end
            default: begin
               base_v = rand40();
               len_v  = ADDR_BITS'(4096);
               frag_v = ADDR_BITS'(30);
            end
         endcase
         csr_write(CSR_REGION_BASE, base_v);
         csr_write(CSR_REGION_LENGTH, len_v);
         csr_write(CSR_FRAGMENT_LOG2, frag_v);

         if (p == 4) hold_armed <= 1'b1;

         // fill the stack past its depth so frees get dropped
         if (p == 1 || p == 4)
            repeat (FILL_BURST) send_item(OP_FREE, pick_amount(), rand40(), 1'b0, '0);

         issued = 0;
         while (issued < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
               // client traffic: allocate, or give back an extent held earlier
               if (held_extents.size() != 0 && $urandom_range(0, 1) == 1) begin
                  idx = $urandom_range(0, held_extents.size() - 1);
                  e   = held_extents[idx];
                  held_extents.delete(idx);
                  send_item(OP_FREE, e.length, e.addr, 1'b0, '0);
               end else begin
                  send_item(OP_ALLOC, pick_amount(), rand40(), 1'b0, '0);
               end
               issued++;
            end else if (kind < 70) begin
               // burst of frees of arbitrary extents
               n = $urandom_range(1, 40);
               repeat (n) send_item(OP_FREE, pick_amount(), rand40(), 1'b0, '0);
               issued += n;
            end else if (kind < 82) begin
               // burst of large requests to empty the stack
               n = $urandom_range(1, 12);
               repeat (n)
                  send_item(OP_ALLOC, ($urandom_range(0, 1) == 1) ? MAX_VAL : rand40(),
                            rand40(), 1'b0, '0);
               issued += n;
            end else begin
               // noise
               send_item(($urandom_range(0, 1) == 1) ? OP_FREE : OP_ALLOC, pick_amount(),
                         rand40(), 1'b0, '0);
               issued++;
            end
         end
         drain();
      end

      $display("covered %0d items: directed rows on reset settings, then %0d region settings",
               items_sent, NUM_PHASES);
      $display("results: %0d granted, %0d no memory, %0d freed, %0d dropped; %0d mismatches",
               status_seen[ST_ALLOCATED], status_seen[ST_NO_MEMORY], status_seen[ST_FREED],
               status_seen[ST_DROPPED], fail_count);
      if (fail_count == 0)
         $display("lifo_extent_allocator regression: pass");
      else
         $display("lifo_extent_allocator regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lea_pkg.sv
rtl/lea_front.sv
rtl/lea_queue.sv
rtl/lea_back.sv
rtl/lifo_extent_allocator.sv
verif/tb.sv
